// ----- design/mrws_pkg.sv -----
// ----------------------------------------------------------------------------
// mrws_pkg: shared definitions for the register write sequencer
// Store geometry, derived widths, action and configuration codes, and the
// packed transaction types of the input and result channels.
// ----------------------------------------------------------------------------
package mrws_pkg;

  // Store geometry and per-tick write limit.
  localparam int unsigned STORE_DEPTH         = 16384;
  localparam int unsigned MAX_WRITES_PER_TICK = 64;

  // Derived widths.
  localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);
  localparam int unsigned LEFT_W   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CNT_W    = $clog2(MAX_WRITES_PER_TICK + 1);
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ENTRY_W  = 32;

  // Field widths fixed by the interface.
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned INDEX_W   = 14;
  localparam int unsigned COMMAND_W = 16;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned REG_W     = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_SONG_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_ENABLE = 1'b1;

  // Action codes of an input transaction.
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [INDEX_W-1:0]   entry_index;
    logic [COMMAND_W-1:0] entry_command;
    logic [DELAY_W-1:0]   entry_delay;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic             write_valid;
    logic [REG_W-1:0] reg_addr;
    logic [REG_W-1:0] reg_value;
    logic             last;
  } out_t;

endpackage

// ----- design/mrws_ram.sv -----
// ----------------------------------------------------------------------------
// mrws_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are undefined until
// written.
// ----------------------------------------------------------------------------
module mrws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- design/music_register_write_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// music_register_write_sequencer_unit: looping song register write sequencer
// Load transactions fill the song store, restart rewinds playback, and each
// enabled tick emits the register writes that have come due, ended by a
// result marked last.
// ----------------------------------------------------------------------------
// Load, restart, ignored and disabled tick transactions leave the sequencer idle.
// A tick emits its writes one at a time: a store read, then the output register;
// the next store read waits until the result channel takes the current write.
// A tick with nothing due presents its one result in the cycle after acceptance.
// Reset clears playback state and both configuration registers; the song
// store is undefined until loaded and needs no clearing pass.
module music_register_write_sequencer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mrws_pkg::in_t                        in_data_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mrws_pkg::out_t                       out_data_o,
  // Configuration port
  input  logic                                 cfg_we_i,
  input  logic [mrws_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mrws_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import mrws_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DATA = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] song_entries_q;
  logic                  music_enable_q;
  logic [STORE_AW-1:0]   pos_q, pos_d;
  logic [LEFT_W-1:0]     left_q, left_d;
  logic [TIME_W-1:0]     tick_q, tick_d;
  logic [TIME_W-1:0]     due_q, due_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  more_q, more_d;
  out_t                  out_q, out_d;

  logic                  ram_we;
  logic                  ram_re;
  logic [STORE_AW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [LEFT_W-1:0]     song_len;
  logic                  idx_ok;
  logic [TIME_W-1:0]     new_due;
  logic [LEFT_W-1:0]     left_dec;
  logic [STORE_AW-1:0]   pos_inc;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  cont;

  // Song store.
  mrws_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  assign ram_waddr = STORE_AW'(in_data_i.entry_index);
  assign ram_wdata = {in_data_i.entry_delay, in_data_i.entry_command};
  assign idx_ok    = 32'(in_data_i.entry_index) < STORE_DEPTH;

  // Song length clamped to the store depth.
  assign song_len = (32'(song_entries_q) > STORE_DEPTH) ? LEFT_W'(STORE_DEPTH)
                                                         : LEFT_W'(song_entries_q);

  // Shared step unit: due time of the entry just read, and the loop test.
  assign new_due  = tick_q + TIME_W'(ram_rdata[ENTRY_W-1:COMMAND_W]);
  assign left_dec = left_q - LEFT_W'(1);
  assign pos_inc  = (32'(pos_q) + 32'd1 >= STORE_DEPTH) ? '0 : pos_q + STORE_AW'(1);
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign cont     = (left_dec != '0) && (new_due <= tick_q)
                    && (32'(cnt_inc) < MAX_WRITES_PER_TICK);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    left_d  = left_q;
    tick_d  = tick_q;
    due_d   = due_q;
    cnt_d   = cnt_q;
    more_d  = more_q;
    out_d   = out_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            ACT_LOAD: begin
              ram_we = idx_ok;
            end
            ACT_RESTART: begin
              pos_d  = '0;
              left_d = song_len;
              tick_d = '0;
              due_d  = '0;
            end
            ACT_TICK: begin
              if (music_enable_q) begin
                cnt_d = '0;
                if ((left_q != '0) && (due_q <= tick_q)) begin
                  ram_re  = 1'b1;
                  state_d = S_DATA;
                end else begin
                  // Nothing due: advance time, or rewind at the song end, and send the empty result.
                  tick_d = tick_q + TIME_W'(1);
                  if (left_q == '0) begin
                    pos_d  = '0;
                    left_d = song_len;
                    tick_d = '0;
                    due_d  = '0;
                  end
                  out_d.write_valid = 1'b0;
                  out_d.reg_addr    = '0;
                  out_d.reg_value   = '0;
                  out_d.last        = 1'b1;
                  more_d            = 1'b0;
                  state_d           = S_OUT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        // Emit the entry read from the store and step playback.
        out_d.write_valid = 1'b1;
        out_d.reg_addr    = ram_rdata[REG_W-1:0];
        out_d.reg_value   = ram_rdata[2*REG_W-1:REG_W];
        out_d.last        = !cont;
        more_d            = cont;
        due_d             = new_due;
        left_d            = left_dec;
        pos_d             = pos_inc;
        cnt_d             = cnt_inc;
        if (!cont) begin
          tick_d = tick_q + TIME_W'(1);
          if (left_dec == '0) begin
            pos_d  = '0;
            left_d = song_len;
            tick_d = '0;
            due_d  = '0;
          end
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (more_q) begin
            ram_re  = 1'b1;
            state_d = S_DATA;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and playback state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      left_q  <= '0;
      tick_q  <= '0;
      due_q   <= '0;
      cnt_q   <= '0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      tick_q  <= tick_d;
      due_q   <= due_d;
      cnt_q   <= cnt_d;
      more_q  <= more_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      song_entries_q <= '0;
      music_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SONG_ENTRIES: song_entries_q <= cfg_data_i;
        CFG_MUSIC_ENABLE: music_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  // An empty result always closes its tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.write_valid) |-> out_data_o.last)
    else $error("empty result without last marker");

  // The per-tick write count never passes the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_WRITES_PER_TICK)
    else $error("write count above per-tick cap");

  // Delivering the last result returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> !in_stall_o)
    else $error("block not ready after last result");

  // Entries left never exceed the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(left_q) <= STORE_DEPTH)
    else $error("entries left above store depth");

endmodule
